/* hdl/credit_code_check_char_core_defines.svh */
// Assertion macros shared by the credit code checker RTL.
// Included by the modules that carry concurrent assertions; no other dependencies.
`ifndef CREDIT_CODE_CHECK_CHAR_CORE_DEFINES_SVH
`define CREDIT_CODE_CHECK_CHAR_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define CCC_ASSERT_HOLDS(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);
`define CCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define CCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CCC_ASSERT_HOLDS(label, clk, rst_n, cond, msg)
`define CCC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`define CCC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* hdl/ccc_pkg.sv */
// Types, constants and lookup functions for the credit code checker.
// No dependencies; imported by ccc_accum and credit_code_check_char_core.
package ccc_pkg;

    localparam int CodeLen  = 18;
    localparam int PosW     = 5;
    localparam int ValW     = 5;

    localparam logic [PosW-1:0] LastPos = PosW'(CodeLen - 1);

    localparam logic [7:0] AsciiZero = 8'h30;

    // Check alphabet for values 10..30.
    localparam logic [7:0] Letters [21] = '{
        8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C,
        8'h4D, 8'h4E, 8'h50, 8'h51, 8'h52, 8'h54, 8'h55, 8'h57, 8'h58, 8'h59
    };

    typedef struct packed {
        logic       code_valid;
        logic [7:0] check_char;
        logic       format_error;
    } t_result;

    typedef struct packed {
        logic            ok;
        logic [ValW-1:0] value;
    } t_char_val;

    // Value 0..30 of an allowed character; ok low if not allowed.
    function automatic t_char_val char_value(input logic [7:0] ch);
        t_char_val r;
        r.ok    = 1'b1;
        r.value = '0;
        case (ch) inside
            [8'h30:8'h39]: r.value = ValW'(ch - 8'h30);
            [8'h41:8'h48]: r.value = ValW'(ch - 8'h41 + 8'd10);  // A..H
            [8'h4A:8'h4E]: r.value = ValW'(ch - 8'h4A + 8'd18);  // J..N
            [8'h50:8'h52]: r.value = ValW'(ch - 8'h50 + 8'd23);  // P..R
            [8'h54:8'h55]: r.value = ValW'(ch - 8'h54 + 8'd26);  // T..U
            [8'h57:8'h59]: r.value = ValW'(ch - 8'h57 + 8'd28);  // W..Y
            default:       r.ok    = 1'b0;
        endcase
        return r;
    endfunction

    // Powers of 3 mod 31 by position.
    function automatic logic [ValW-1:0] weight(input logic [PosW-1:0] pos);
        logic [ValW-1:0] w;
        case (pos)
            5'd0:    w = 5'd1;
            5'd1:    w = 5'd3;
            5'd2:    w = 5'd9;
            5'd3:    w = 5'd27;
            5'd4:    w = 5'd19;
            5'd5:    w = 5'd26;
            5'd6:    w = 5'd16;
            5'd7:    w = 5'd17;
            5'd8:    w = 5'd20;
            5'd9:    w = 5'd29;
            5'd10:   w = 5'd25;
            5'd11:   w = 5'd13;
            5'd12:   w = 5'd8;
            5'd13:   w = 5'd24;
            5'd14:   w = 5'd10;
            5'd15:   w = 5'd30;
            5'd16:   w = 5'd28;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

    // x mod 31 for x below 1023: fold the two 5-bit halves (32 = 1 mod 31),
    // then one compare and subtract.
    function automatic logic [ValW-1:0] mod31(input logic [9:0] x);
        logic [5:0] y;
        y = {1'b0, x[9:5]} + {1'b0, x[4:0]};
        if (y >= 6'd31) begin
            y = y - 6'd31;
        end
        return y[ValW-1:0];
    endfunction

    // ASCII check character for a weighted sum already reduced mod 31.
    function automatic logic [7:0] check_ascii(input logic [ValW-1:0] sum);
        logic [ValW-1:0] t;
        logic [7:0]      c;
        t = (sum == '0) ? '0 : ValW'(5'd31 - sum);
        if (t < ValW'(10)) begin
            c = AsciiZero + {3'b000, t};
        end else begin
            c = Letters[ValW'(t - ValW'(10))];
        end
        return c;
    endfunction

endpackage

/* hdl/ccc_accum.sv */
// Per-character format check and weighted mod-31 accumulator for the credit code checker.
// Depends on ccc_pkg and the assertion macros in credit_code_check_char_core_defines.svh.
`include "credit_code_check_char_core_defines.svh"
module ccc_accum (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_char_code,
    input  logic              i_first,
    output logic              o_emit,
    output ccc_pkg::t_result  o_result
);
    import ccc_pkg::*;

    logic [PosW-1:0] r_position, n_position;
    logic [ValW-1:0] r_sum, n_sum;
    logic            r_bad, n_bad;

    logic [PosW-1:0] pos;
    logic [ValW-1:0] sum_in;
    logic            bad_in;
    t_char_val       cv;
    logic            is_digit;
    logic            bad_now;
    logic [9:0]      acc;
    logic [7:0]      chk;

    always_comb begin
        // a first mark restarts the code before this character counts
        pos    = i_first ? '0 : r_position;
        sum_in = i_first ? '0 : r_sum;
        bad_in = i_first ? 1'b0 : r_bad;
        if (pos > LastPos) begin
            pos = '0;
        end

        cv       = char_value(i_char_code);
        is_digit = (i_char_code >= 8'h30) && (i_char_code <= 8'h39);

        bad_now = bad_in || !cv.ok;
        if (pos == PosW'(0) && !(i_char_code inside {8'h31, 8'h35, 8'h39, 8'h59})) begin
            bad_now = 1'b1;
        end
        if (pos == PosW'(1) && !(i_char_code inside {8'h31, 8'h32, 8'h33, 8'h39})) begin
            bad_now = 1'b1;
        end
        if (pos >= PosW'(2) && pos <= PosW'(7) && !is_digit) begin
            bad_now = 1'b1;
        end

        // at most 30 * 30 + 30, fits in 10 bits
        acc = {5'b00000, cv.value} * {5'b00000, weight(pos)} + {5'b00000, sum_in};

        o_emit = (pos == LastPos);
        chk    = bad_in ? 8'h00 : check_ascii(sum_in);

        o_result.check_char   = chk;
        o_result.format_error = bad_in;
        o_result.code_valid   = !bad_in && (i_char_code == chk);

        if (o_emit) begin
            n_position = '0;
            n_sum      = '0;
            n_bad      = 1'b0;
        end else begin
            n_position = pos + PosW'(1);
            n_sum      = cv.ok ? mod31(acc) : sum_in;
            n_bad      = bad_now;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_position <= '0;
            r_sum      <= '0;
            r_bad      <= 1'b0;
        end else if (i_advance) begin
            r_position <= n_position;
            r_sum      <= n_sum;
            r_bad      <= n_bad;
        end
    end

    `CCC_ASSERT_HOLDS(a_pos_range, i_clk, i_rst_n, r_position <= LastPos, "position past end")
    `CCC_ASSERT_HOLDS(a_sum_reduced, i_clk, i_rst_n, r_sum != 5'd31, "sum not reduced mod 31")
    `CCC_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, i_advance && o_emit, (r_position == '0) && (r_sum == '0) && !r_bad, "state not cleared after last char")

endmodule

/* hdl/credit_code_check_char_core.sv */
// Top level of the unified social credit code checker: input register, accumulator, result register.
// Depends on ccc_pkg, ccc_accum and credit_code_check_char_core_defines.svh.
// A code's result becomes valid on the outputs once its 18th character transaction has been
// accepted and passed the input register, then the result register.
// Throughput: one character per cycle unless stalled; the input register feeds the accumulator.
// A stalled result only holds back the 18th character of the next code; others keep flowing.
// Reset (i_rst_n low, synchronous): clears both valid flags, position, sum and error flag.
`include "credit_code_check_char_core_defines.svh"
module credit_code_check_char_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // character channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_char_code,
    input  logic       i_first,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_code_valid,
    output logic [7:0] o_check_char,
    output logic       o_format_error
);
    import ccc_pkg::*;

    // Input register: one character transaction waiting for the accumulator.
    logic       r_s1_valid;
    logic [7:0] r_s1_char;
    logic       r_s1_first;

    // Result register.
    logic       r_out_valid;
    t_result    r_out;

    logic       emit;
    t_result    result;
    logic       out_free;
    logic       s1_advance;
    logic       in_accept;

    // The result register can take a new result when empty or being drained.
    assign out_free   = !r_out_valid || !i_out_stall;
    // A character that closes a code needs the result register; others never wait.
    assign s1_advance = r_s1_valid && (!emit || out_free);
    assign o_in_stall = r_s1_valid && !s1_advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_s1_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_s1_char  <= i_char_code;
            r_s1_first <= i_first;
        end
    end

    ccc_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (s1_advance),
        .i_char_code (r_s1_char),
        .i_first     (r_s1_first),
        .o_emit      (emit),
        .o_result    (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= s1_advance && emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free && s1_advance && emit) begin
            r_out <= result;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_code_valid   = r_out.code_valid;
    assign o_check_char   = r_out.check_char;
    assign o_format_error = r_out.format_error;

    `CCC_ASSERT_IMP(a_empty_no_stall, i_clk, i_rst_n, !r_s1_valid, !o_in_stall, "stall with empty input register")
    `CCC_ASSERT_NXT(a_result_lands, i_clk, i_rst_n, s1_advance && emit, r_out_valid, "result transaction lost")
    `CCC_ASSERT_IMP(a_blocked_end, i_clk, i_rst_n, r_s1_valid && emit && r_out_valid && i_out_stall, o_in_stall, "last char advanced into full result register")

endmodule

/* tb/credit_code_check_char_core_tb.sv */
// Testbench for credit_code_check_char_core: streams credit codes one character per
// transaction and checks every result against a cycle-free predictor held in a scoreboard.
// Depends on ccc_pkg (result type) and the credit_code_check_char_core RTL.
module credit_code_check_char_core_tb;

    import ccc_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int RANDOM_ITEMS = 1850;
    localparam int TIMEOUT_CYCLES = 600000;

    // Check alphabet for values 10..30, first letter in the top byte.
    localparam logic [8*21-1:0] CHECK_LETTERS = "ABCDEFGHJKLMNPQRTUWXY";
    localparam logic [7:0] DIGIT_ZERO = "0";
    localparam logic [8*4-1:0] LEAD_CHARS = "159Y";
    localparam logic [8*4-1:0] KIND_CHARS = "1239";
    localparam int MOD_BASE = 31;

    typedef logic [7:0] t_code [18];

    // Scoreboard: tracks the checker state per accepted character and holds
    // the expected result of every completed code until it shows up.
    class code_scoreboard;
        t_result pending[$];
        int errors = 0;
        int pos = 0;       // index of the next character, 0..17
        int wsum = 0;      // weighted sum mod 31
        bit bad = 1'b0;    // format rule broken somewhere in this code

        // Value 0..30 to its code symbol: digit or one of the 21 letters.
        static function logic [7:0] symbol(input int v);
            if (v < 10) begin
                return DIGIT_ZERO + 8'(v);
            end
            return CHECK_LETTERS[8*(30-v) +: 8];
        endfunction

        // Symbol back to its value, -1 for anything outside the alphabet.
        static function int char_val(input logic [7:0] ch);
            for (int k = 0; k < MOD_BASE; k++) begin
                if (symbol(k) == ch) begin
                    return k;
                end
            end
            return -1;
        endfunction

        // 3**p mod 31
        static function int weight_at(input int p);
            int w;
            w = 1;
            for (int k = 0; k < p; k++) begin
                w = (w * 3) % MOD_BASE;
            end
            return w;
        endfunction

        static function logic [7:0] check_symbol(input int s);
            return symbol((s == 0) ? 0 : MOD_BASE - s);
        endfunction

        function void note_char(input logic [7:0] ch, input logic first);
            int val;
            t_result want;
            if (first) begin
                pos  = 0;
                wsum = 0;
                bad  = 1'b0;
            end
            if (pos < 17) begin
                val = char_val(ch);
                if (val < 0) begin
                    bad = 1'b1;
                end
                if (pos == 0 && !(ch inside {"1", "5", "9", "Y"})) begin
                    bad = 1'b1;
                end
                if (pos == 1 && !(ch inside {"1", "2", "3", "9"})) begin
                    bad = 1'b1;
                end
                if (pos >= 2 && pos <= 7 && !(ch inside {["0":"9"]})) begin
                    bad = 1'b1;
                end
                if (val >= 0) begin
                    wsum = (wsum + val * weight_at(pos)) % MOD_BASE;
                end
                pos++;
            end else begin
                // last character: compare only, then start over
                want.check_char   = bad ? 8'h00 : check_symbol(wsum);
                want.format_error = bad;
                want.code_valid   = !bad && (ch == want.check_char);
                pending.push_back(want);
                pos  = 0;
                wsum = 0;
                bad  = 1'b0;
            end
        endfunction

        function void check_result(input t_result got);
            t_result want;
            if (pending.size() == 0) begin
                $error("result with no code pending: code_valid %0b check_char %02h format_error %0b",
                       got.code_valid, got.check_char, got.format_error);
                errors++;
                return;
            end
            want = pending.pop_front();
            if (got.code_valid !== want.code_valid) begin
                $error("code_valid: expected %0b, got %0b", want.code_valid, got.code_valid);
                errors++;
            end
            if (got.check_char !== want.check_char) begin
                $error("check_char: expected %02h, got %02h", want.check_char, got.check_char);
                errors++;
            end
            if (got.format_error !== want.format_error) begin
                $error("format_error: expected %0b, got %0b",
                       want.format_error, got.format_error);
                errors++;
            end
        endfunction
    endclass

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [7:0] i_char_code;
    logic       i_first;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_code_valid;
    logic [7:0] o_check_char;
    logic       o_format_error;

    code_scoreboard sb = new();
    int  items_sent = 0;
    int  results_seen = 0;
    bit  burst = 1'b0;      // sender runs without gaps for the current code
    t_code body;

    credit_code_check_char_core uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_char_code    (i_char_code),
        .i_first        (i_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_code_valid   (o_code_valid),
        .o_check_char   (o_check_char),
        .o_format_error (o_format_error)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD/2) i_clk = ~i_clk;
    end

    // Idle length shared by both sides: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) begin
            return 0;
        end else if (r < 93) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(5, 40);
    endfunction

    // Check symbol for the first 17 characters of a well-formed code.
    function automatic logic [7:0] check_for(input t_code c);
        int s;
        s = 0;
        for (int k = 0; k < 17; k++) begin
            s = (s + code_scoreboard::char_val(c[k]) * code_scoreboard::weight_at(k)) % MOD_BASE;
        end
        return code_scoreboard::check_symbol(s);
    endfunction

    // One character transaction. Valid stays high while stalled; payload is
    // held. The gap after it, if any, drops valid for whole cycles.
    task automatic send_char(input logic [7:0] ch, input logic first);
        int gap;
        i_in_valid  <= 1'b1;
        i_char_code <= ch;
        i_first     <= first;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_char(ch, first);
        items_sent++;
        gap = burst ? 0 : idle_len();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // One random code. Most are well formed (some with a wrong last
    // character), the rest carry a format fault, get cut short, or are noise.
    task automatic send_code();
        t_code c;
        int    kind;
        int    len;
        int    at;
        logic  mark;
        kind  = $urandom_range(0, 99);
        burst = ($urandom_range(0, 3) == 0);
        if (kind >= 93) begin
            // noise: arbitrary bytes, a first mark now and then
            len = $urandom_range(1, 40);
            for (int k = 0; k < len; k++) begin
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            end
            return;
        end
        c[0] = LEAD_CHARS[8*$urandom_range(0, 3) +: 8];
        c[1] = KIND_CHARS[8*$urandom_range(0, 3) +: 8];
        for (int k = 2; k < 8; k++) begin
            c[k] = DIGIT_ZERO + 8'($urandom_range(0, 9));
        end
        for (int k = 8; k < 17; k++) begin
            c[k] = code_scoreboard::symbol($urandom_range(0, 30));
        end
        c[17] = check_for(c);
        len = 18;
        if (kind >= 85) begin
            len = $urandom_range(1, 17);
        end else if (kind >= 75) begin
            // one broken character: lowercase letter or any byte
            at = $urandom_range(0, 16);
            c[at] = ($urandom_range(0, 1) == 1) ? 8'("a" + $urandom_range(0, 25))
                                                : 8'($urandom_range(0, 255));
        end else if (kind >= 60) begin
            // last character is not checked for format, only compared
            c[17] = 8'($urandom_range(0, 255));
        end
        // after a full code the position is back at 0, so the mark is optional
        mark = ($urandom_range(0, 4) != 0);
        for (int k = 0; k < len; k++) begin
            send_char(c[k], (k == 0) ? mark : 1'b0);
        end
    endtask

    // Result side: checks each accepted result, then picks the next stall.
    // One long hold after a few dozen results lets the block back up.
    initial begin
        int  left;
        bit  hold_done;
        logic stall;
        left      = 0;
        hold_done = 1'b0;
        stall     = 1'b0;
        i_out_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) begin
                sb.check_result('{code_valid: o_code_valid, check_char: o_check_char,
                                  format_error: o_format_error});
                results_seen++;
            end
            if (left > 0) begin
                left--;
            end else if (!hold_done && results_seen >= 30) begin
                stall     = 1'b1;
                left      = 400;
                hold_done = 1'b1;
            end else if ($urandom_range(0, 2) == 0) begin
                stall = 1'b0;
                left  = $urandom_range(0, 25);   // stall-free stretch
            end else begin
                left  = idle_len();
                stall = (left > 0);
            end
            i_out_stall <= stall;
        end
    end

    // Stimulus: reset, directed codes, a drain pause, random codes, drain, verdict.
    initial begin
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_char_code <= 8'h00;
        i_first     <= 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // well-formed code straight after reset, no first mark
        body = '{"9", "1", "1", "1", "0", "1", "0", "8", "M", "A",
                 "0", "1", "A", "B", "C", "D", "E", "0"};
        body[17] = check_for(body);
        for (int k = 0; k < 18; k++) begin
            send_char(body[k], 1'b0);
        end
        // fresh code with the byte extremes, lowercase and excluded letters;
        // it is left open and cut off by the first random code or runs on
        send_char("Y", 1'b1);
        send_char(8'h00, 1'b0);
        send_char(8'hFF, 1'b0);
        send_char("a", 1'b0);
        send_char("I", 1'b0);
        send_char("O", 1'b0);
        send_char("S", 1'b0);

        // sender pause until every pending result is back
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);

        while (items_sent < RANDOM_ITEMS) begin
            send_code();
        end

        i_in_valid <= 1'b0;
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
